// ----- rtl/core/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants of the hashed page table walker: sizes, command,
// status and configuration register codes.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned TABLE_DEPTH      = 1024;
  localparam int unsigned NUM_TABLES       = 2;
  localparam int unsigned BLOCKS_PER_ENTRY = 4;

  localparam int unsigned SLOT_W  = 10;  // slot within one table
  localparam int unsigned META_AW = 11;  // table and slot
  localparam int unsigned PPN_AW  = 13;  // table, slot and block
  localparam int unsigned TAG_W   = 34;
  localparam int unsigned PPN_W   = 40;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned META_W  = 1 + BLOCKS_PER_ENTRY + TAG_W;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FILLED   = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [2:0] CFG_SHIFT_SMALL   = 3'd0;
  localparam logic [2:0] CFG_SHIFT_LARGE   = 3'd1;
  localparam logic [2:0] CFG_ENTRIES_SMALL = 3'd2;
  localparam logic [2:0] CFG_ENTRIES_LARGE = 3'd3;
  localparam logic [2:0] CFG_TABLES        = 3'd4;
  localparam logic [2:0] CFG_PROBE_LIMIT   = 3'd5;

endpackage

// ----- rtl/core/hashed_page_table_walker_top.sv -----
// ----------------------------------------------------------------------------
// hashed_page_table_walker_top
// Hashed page table with two page-size tables and linear probing.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one command beat: lookup with
// fault fill, insert or delete. Output channel (out_valid_o/out_ready_i)
// returns one result beat per command. Configuration writes go through
// cfg_we_i/cfg_idx_i/cfg_data_i and are for the user to make only while
// the block is idle; the block itself does not enforce this. A command is
// handled one at a time by a sequencer around one shared restoring modulo
// unit (tag mod entries) and one tag memory port: each table walk runs a
// setup step, the bit-serial modulo over the 34-bit tag, then a read and a
// compare step per probed slot; a result then waits in S_FIN until the
// output register is free. A lookup miss over both tables with a fill walks
// three times; an unknown command goes straight to S_FIN. After reset the
// tag memory is swept clear, one entry per cycle, while in_ready_o stays low.
// The output register holds a finished result while the receiver stalls;
// the next command is accepted meanwhile, and its result waits in the
// sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module hashed_page_table_walker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [47:0] vaddr_i,
  input  logic [39:0] new_ppn_i,
  input  logic        table_sel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [39:0] ppn_o,
  output logic [5:0]  page_shift_o,
  output logic [11:0] probe_count_o,
  output logic [9:0]  slot_index_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_DIV, S_RD, S_CMP, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MD_LOOKUP, MD_PLACE, MD_DELETE
  } mode_e;

  // configuration
  logic [5:0]  shift_small_q, shift_large_q;
  logic [10:0] entries_small_q, entries_large_q;
  logic [1:0]  tables_q;
  logic [10:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_small_q   <= 6'd12;
      shift_large_q   <= 6'd21;
      entries_small_q <= 11'd1024;
      entries_large_q <= 11'd1024;
      tables_q        <= 2'd2;
      limit_q         <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hpt_pkg::CFG_SHIFT_SMALL:   shift_small_q   <= cfg_data_i[5:0];
        hpt_pkg::CFG_SHIFT_LARGE:   shift_large_q   <= cfg_data_i[5:0];
        hpt_pkg::CFG_ENTRIES_SMALL: entries_small_q <= cfg_data_i;
        hpt_pkg::CFG_ENTRIES_LARGE: entries_large_q <= cfg_data_i;
        hpt_pkg::CFG_TABLES:        tables_q        <= cfg_data_i[1:0];
        hpt_pkg::CFG_PROBE_LIMIT:   limit_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e      state_q;
  mode_e       mode_q;
  logic [10:0] clr_cnt_q;
  logic [1:0]  cmd_q;
  logic [47:0] vaddr_q;
  logic [39:0] nppn_q;
  logic        t_q;
  logic [33:0] tag_q;
  logic [1:0]  blk_q;
  logic [33:0] div_tag_q;
  logic [9:0]  rem_q;
  logic [5:0]  div_cnt_q;
  logic [9:0]  s_q;
  logic [10:0] i_q;
  logic [11:0] probes_q;
  logic [9:0]  slot_q;
  logic [2:0]  res_status_q;
  logic        res_use_rd_q;
  logic [39:0] res_ppn_q;
  logic [5:0]  res_shift_q;

  // output register
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [39:0] ppn_q;
  logic [5:0]  pshift_q;
  logic [11:0] pcount_q;
  logic [9:0]  slot_out_q;

  // memories
  logic [hpt_pkg::META_W-1:0] meta_mem [2**hpt_pkg::META_AW];
  logic [hpt_pkg::PPN_W-1:0]  ppn_mem  [2**hpt_pkg::PPN_AW];
  logic [hpt_pkg::META_W-1:0] meta_rdata_q;
  logic [hpt_pkg::PPN_W-1:0]  ppn_rdata_q;

  logic                       meta_re, meta_we, ppn_re, ppn_we;
  logic [hpt_pkg::META_AW-1:0] meta_addr;
  logic [hpt_pkg::META_W-1:0] meta_wdata;
  logic [hpt_pkg::PPN_AW-1:0] ppn_addr;

  // effective configuration of the current table
  logic [5:0]  sh_raw, eff_sh, tag_sh;
  logic [10:0] n_raw, eff_n, eff_lim;
  logic        two_tables;
  logic [47:0] va_tag, va_blk;

  always_comb begin
    sh_raw = t_q ? shift_large_q : shift_small_q;
    if (sh_raw < 6'd12) begin
      eff_sh = 6'd12;
    end else if (sh_raw > 6'd39) begin
      eff_sh = 6'd39;
    end else begin
      eff_sh = sh_raw;
    end
    n_raw = t_q ? entries_large_q : entries_small_q;
    if (n_raw == 11'd0) begin
      eff_n = 11'd1;
    end else if (n_raw > 11'd1024) begin
      eff_n = 11'd1024;
    end else begin
      eff_n = n_raw;
    end
    if (limit_q == 11'd0) begin
      eff_lim = 11'd1;
    end else if (limit_q > 11'd1024) begin
      eff_lim = 11'd1024;
    end else begin
      eff_lim = limit_q;
    end
    two_tables = (tables_q >= 2'd2);
    tag_sh     = eff_sh + 6'd2;
    va_tag     = vaddr_q >> tag_sh;
    va_blk     = vaddr_q >> eff_sh;
  end

  // modulo step
  logic [10:0] rem_sh, rem_sub;
  logic [9:0]  rem_nx;

  always_comb begin
    rem_sh  = {rem_q, div_tag_q[33]};
    rem_sub = rem_sh - eff_n;
    rem_nx  = (rem_sh >= eff_n) ? rem_sub[9:0] : rem_sh[9:0];
  end

  // probe evaluation
  logic        m_used, tag_eq, o_match, o_hit, o_limit, o_step, last;
  logic [3:0]  m_valid, blk_oh;
  logic [33:0] m_tag;
  logic [10:0] s_inc, i_inc;
  logic [9:0]  s_next;

  always_comb begin
    m_used  = meta_rdata_q[hpt_pkg::META_W-1];
    m_valid = meta_rdata_q[hpt_pkg::TAG_W +: 4];
    m_tag   = meta_rdata_q[hpt_pkg::TAG_W-1:0];
    blk_oh  = 4'b0001 << blk_q;
    tag_eq  = (m_tag == tag_q);
    o_match = m_used && tag_eq;
    o_hit   = o_match && m_valid[blk_q];
    i_inc   = i_q + 11'd1;
    last    = (i_inc == eff_lim);
    o_limit = m_used && !tag_eq && last;
    o_step  = m_used && !tag_eq && !last;
    s_inc   = {1'b0, s_q} + 11'd1;
    s_next  = (s_inc >= eff_n) ? 10'd0 : s_inc[9:0];
  end

  // memory control
  always_comb begin
    meta_re    = (state_q == S_RD);
    meta_we    = 1'b0;
    meta_addr  = {t_q, s_q};
    meta_wdata = '0;
    ppn_re     = 1'b0;
    ppn_we     = 1'b0;
    ppn_addr   = {t_q, s_q, blk_q};
    if (state_q == S_CLEAR) begin
      meta_we   = 1'b1;
      meta_addr = clr_cnt_q;
    end else if (state_q == S_CMP && !o_step) begin
      if (mode_q == MD_PLACE && !o_limit) begin
        meta_we    = 1'b1;
        meta_wdata = {1'b1, (m_used ? m_valid : 4'b0000) | blk_oh, tag_q};
        ppn_we     = 1'b1;
      end else if (mode_q == MD_DELETE && o_hit) begin
        meta_we    = 1'b1;
        meta_wdata = {1'b1, m_valid & ~blk_oh, m_tag};
        ppn_re     = 1'b1;
      end else if (mode_q == MD_LOOKUP && o_hit) begin
        ppn_re     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_addr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata_q <= meta_mem[meta_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ppn_we) begin
      ppn_mem[ppn_addr] <= nppn_q;
    end
    if (ppn_re) begin
      ppn_rdata_q <= ppn_mem[ppn_addr];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      mode_q       <= MD_LOOKUP;
      clr_cnt_q    <= '0;
      cmd_q        <= '0;
      vaddr_q      <= '0;
      nppn_q       <= '0;
      t_q          <= 1'b0;
      tag_q        <= '0;
      blk_q        <= '0;
      div_tag_q    <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      s_q          <= '0;
      i_q          <= '0;
      probes_q     <= '0;
      slot_q       <= '0;
      res_status_q <= hpt_pkg::ST_ABSENT;
      res_use_rd_q <= 1'b0;
      res_ppn_q    <= '0;
      res_shift_q  <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      ppn_q        <= '0;
      pshift_q     <= '0;
      pcount_q     <= '0;
      slot_out_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 11'd1;
          if (clr_cnt_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= cmd_i;
            vaddr_q      <= vaddr_i;
            nppn_q       <= new_ppn_i;
            probes_q     <= '0;
            slot_q       <= '0;
            res_use_rd_q <= 1'b0;
            res_ppn_q    <= '0;
            res_shift_q  <= '0;
            res_status_q <= hpt_pkg::ST_ABSENT;
            t_q          <= (cmd_i == hpt_pkg::CMD_INSERT) ? table_sel_i : 1'b0;
            case (cmd_i)
              hpt_pkg::CMD_LOOKUP: begin
                mode_q  <= MD_LOOKUP;
                state_q <= S_SETUP;
              end
              hpt_pkg::CMD_INSERT: begin
                mode_q  <= MD_PLACE;
                state_q <= S_SETUP;
              end
              hpt_pkg::CMD_DELETE: begin
                mode_q  <= MD_DELETE;
                state_q <= S_SETUP;
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_SETUP: begin
          tag_q     <= va_tag[33:0];
          div_tag_q <= va_tag[33:0];
          blk_q     <= va_blk[1:0];
          rem_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          rem_q     <= rem_nx;
          div_tag_q <= {div_tag_q[32:0], 1'b0};
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(hpt_pkg::TAG_W - 1)) begin
            s_q     <= rem_nx;
            i_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          probes_q <= probes_q + 12'd1;
          slot_q   <= s_q;
          if (o_step) begin
            s_q     <= s_next;
            i_q     <= i_inc;
            state_q <= S_RD;
          end else begin
            res_shift_q <= eff_sh;
            case (mode_q)
              MD_LOOKUP: begin
                if (o_hit) begin
                  res_status_q <= hpt_pkg::ST_HIT;
                  res_use_rd_q <= 1'b1;
                  state_q      <= S_FIN;
                end else if (!t_q && two_tables) begin
                  t_q     <= 1'b1;
                  state_q <= S_SETUP;
                end else begin
                  t_q     <= 1'b0;
                  mode_q  <= MD_PLACE;
                  state_q <= S_SETUP;
                end
              end
              MD_PLACE: begin
                if (o_limit) begin
                  res_status_q <= hpt_pkg::ST_FULL;
                end else begin
                  res_status_q <= (cmd_q == hpt_pkg::CMD_LOOKUP) ?
                                  hpt_pkg::ST_FILLED : hpt_pkg::ST_INSERTED;
                  res_ppn_q    <= nppn_q;
                end
                state_q <= S_FIN;
              end
              default: begin
                if (o_hit) begin
                  res_status_q <= hpt_pkg::ST_DELETED;
                  res_use_rd_q <= 1'b1;
                end else begin
                  res_status_q <= hpt_pkg::ST_ABSENT;
                end
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            ppn_q       <= res_use_rd_q ? ppn_rdata_q : res_ppn_q;
            pshift_q    <= res_shift_q;
            pcount_q    <= probes_q;
            slot_out_q  <= slot_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign ppn_o         = ppn_q;
  assign page_shift_o  = pshift_q;
  assign probe_count_o = pcount_q;
  assign slot_index_o  = slot_out_q;

endmodule

// ----- rtl/core/hpt_checker.sv -----
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the hashed page table walker result channel.
// ----------------------------------------------------------------------------
module hpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [39:0] ppn_o,
  input logic [5:0]  page_shift_o,
  input logic [11:0] probe_count_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(ppn_o))
    else $error("result beat changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= hpt_pkg::ST_FULL)
    else $error("status code out of range");

  // no translation on a miss or a full table
  a_ppn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == hpt_pkg::ST_ABSENT || status_o == hpt_pkg::ST_FULL)
    |-> ppn_o == '0)
    else $error("nonzero ppn on miss");

  // any answering walk probed at least one slot with a legal page shift
  a_walk_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != hpt_pkg::ST_ABSENT
    |-> probe_count_o != '0 && page_shift_o >= 6'd12 && page_shift_o <= 6'd39)
    else $error("answer without a walk");

endmodule

bind hashed_page_table_walker_top hpt_checker u_hpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .ppn_o         (ppn_o),
  .page_shift_o  (page_shift_o),
  .probe_count_o (probe_count_o)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hashed page table walker: directed and random
// lookup, insert, delete and reserved-command beats through several table configurations,
// checked field by field against a behavioral model of the probing tables.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] vaddr;
    logic [39:0] new_ppn;
    logic        table_sel;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [39:0] ppn;
    logic [5:0]  page_shift;
    logic [11:0] probe_count;
    logic [9:0]  slot_index;
  } result_beat_t;

  localparam int WALK_HIT = 0, WALK_TAGMISS = 1, WALK_FREE = 2, WALK_LIMIT = 3;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned DEPTH = hpt_pkg::TABLE_DEPTH;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [47:0] vaddr_i = '0;
  logic [39:0] new_ppn_i = '0;
  logic        table_sel_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [39:0] ppn_o;
  logic [5:0]  page_shift_o;
  logic [11:0] probe_count_o;
  logic [9:0]  slot_index_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;

  hashed_page_table_walker_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic [5:0]  shift_small_q, shift_large_q;
  logic [10:0] entries_small_q, entries_large_q, probe_limit_q;
  logic [1:0]  tables_q;
  logic [33:0] tag_mem [2*DEPTH];
  logic        tag_used [2*DEPTH];
  logic [3:0]  blk_valid [2*DEPTH];
  logic [39:0] blk_ppn [8*DEPTH];

  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  accepted = 0;
  int  checked = 0;
  int  hits = 0, faults = 0, fulls = 0;
  bit  idle_free = 1'b0;
  bit  hold_start = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  send_gap = 0, recv_gap = 0;
  logic last_taken = 1'b0;
  logic [47:0] recent_va [$];

  function automatic int unsigned eff_shift(int t);
    int unsigned s;
    s = t ? shift_large_q : shift_small_q;
    if (s < 12) s = 12;
    if (s > 39) s = 39;
    return s;
  endfunction

  function automatic int unsigned eff_entries(int t);
    int unsigned n;
    n = t ? entries_large_q : entries_small_q;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic int unsigned eff_limit();
    int unsigned l;
    l = probe_limit_q;
    if (l < 1) l = 1;
    if (l > 1024) l = 1024;
    return l;
  endfunction

  function automatic int walk_table(int t, logic [47:0] va, inout int unsigned slot,
                                    inout int unsigned probes);
    int unsigned sh, n, lim, s, idx;
    logic [47:0] tag;
    int blk;
    sh = eff_shift(t);
    n = eff_entries(t);
    lim = eff_limit();
    tag = va >> (sh + 2);
    blk = int'((va >> sh) & 48'd3);
    s = 32'(tag % 48'(n));
    for (int unsigned i = 0; i < lim; i++) begin
      if (i != 0) s = (s + 1 >= n) ? 0 : s + 1;
      slot = s;
      probes++;
      idx = t * DEPTH + s;
      if (!tag_used[idx]) return WALK_FREE;
      if ({14'b0, tag_mem[idx]} == tag) return blk_valid[idx][blk] ? WALK_HIT : WALK_TAGMISS;
    end
    return WALK_LIMIT;
  endfunction

  function automatic bit place_block(int t, logic [47:0] va, logic [39:0] ppn,
                                     inout int unsigned slot, inout int unsigned probes);
    int unsigned sh, idx;
    int r, blk;
    sh = eff_shift(t);
    blk = int'((va >> sh) & 48'd3);
    r = walk_table(t, va, slot, probes);
    idx = t * DEPTH + slot;
    if (r == WALK_LIMIT) return 1'b0;
    if (r == WALK_FREE) begin
      tag_mem[idx] = 34'(va >> (sh + 2));
      tag_used[idx] = 1'b1;
      blk_valid[idx] = '0;
    end
    blk_valid[idx][blk] = 1'b1;
    blk_ppn[idx * 4 + blk] = ppn;
    return 1'b1;
  endfunction

  function automatic result_beat_t translate(cmd_beat_t c);
    result_beat_t r;
    int unsigned probes, slot, s, sh, tu;
    int blk;
    bit hit;
    r = '0;
    r.status = hpt_pkg::ST_ABSENT;
    probes = 0;
    slot = 0;
    if (c.cmd == hpt_pkg::CMD_LOOKUP) begin
      tu = tables_q;
      if (tu < 1) tu = 1;
      if (tu > hpt_pkg::NUM_TABLES) tu = hpt_pkg::NUM_TABLES;
      hit = 1'b0;
      for (int t = 0; t < tu && !hit; t++) begin
        s = 0;
        if (walk_table(t, c.vaddr, s, probes) == WALK_HIT) begin
          sh = eff_shift(t);
          blk = int'((c.vaddr >> sh) & 48'd3);
          r.status = hpt_pkg::ST_HIT;
          r.ppn = blk_ppn[(t * DEPTH + s) * 4 + blk];
          r.page_shift = 6'(sh);
          slot = s;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        r.page_shift = 6'(eff_shift(0));
        if (place_block(0, c.vaddr, c.new_ppn, slot, probes)) begin
          r.status = hpt_pkg::ST_FILLED;
          r.ppn = c.new_ppn;
        end else r.status = hpt_pkg::ST_FULL;
      end
    end else if (c.cmd == hpt_pkg::CMD_INSERT) begin
      r.page_shift = 6'(eff_shift(c.table_sel));
      if (place_block(c.table_sel, c.vaddr, c.new_ppn, slot, probes)) begin
        r.status = hpt_pkg::ST_INSERTED;
        r.ppn = c.new_ppn;
      end else r.status = hpt_pkg::ST_FULL;
    end else if (c.cmd == hpt_pkg::CMD_DELETE) begin
      sh = eff_shift(0);
      blk = int'((c.vaddr >> sh) & 48'd3);
      r.page_shift = 6'(sh);
      if (walk_table(0, c.vaddr, slot, probes) == WALK_HIT) begin
        r.status = hpt_pkg::ST_DELETED;
        r.ppn = blk_ppn[slot * 4 + blk];
        blk_valid[slot][blk] = 1'b0;
      end
    end
    r.probe_count = 12'(probes);
    r.slot_index = 10'(slot);
    return r;
  endfunction

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o) begin
      expected_results = {expected_results,
                          translate({cmd_i, vaddr_i, new_ppn_i, table_sel_i})};
      accepted++;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        result_beat_t e;
        e = expected_results.pop_front();
        checked++;
        if (e.status == hpt_pkg::ST_HIT) hits++;
        if (e.status == hpt_pkg::ST_FILLED) faults++;
        if (e.status == hpt_pkg::ST_FULL) fulls++;
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (ppn_o !== e.ppn) begin
          $error("ppn expected %h actual %h", e.ppn, ppn_o);
          errors++;
        end
        if (page_shift_o !== e.page_shift) begin
          $error("page_shift expected %0d actual %0d", e.page_shift, page_shift_o);
          errors++;
        end
        if (probe_count_o !== e.probe_count) begin
          $error("probe_count expected %0d actual %0d", e.probe_count, probe_count_o);
          errors++;
        end
        if (slot_index_o !== e.slot_index) begin
          $error("slot_index expected %0d actual %0d", e.slot_index, slot_index_o);
          errors++;
        end
      end
    end
  end

  // accept flag sampled at the rising edge
  always @(posedge clk_i) last_taken <= in_valid_i && in_ready_o;

  // sender, changes at falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || (in_valid_i && last_taken)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          cmd_i <= c.cmd;
          vaddr_i <= c.vaddr;
          new_ppn_i <= c.new_ppn;
          table_sel_i <= c.table_sel;
          in_valid_i <= 1'b1;
          if (!idle_free && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver stall, counted here
  always @(negedge clk_i) begin
    if (hold_start && !hold_done) begin
      if (hold_cnt == 399) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_start && !hold_done) begin
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!idle_free && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 16);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 40000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hpt_pkg::CFG_SHIFT_SMALL:   shift_small_q = val[5:0];
      hpt_pkg::CFG_SHIFT_LARGE:   shift_large_q = val[5:0];
      hpt_pkg::CFG_ENTRIES_SMALL: entries_small_q = val;
      hpt_pkg::CFG_ENTRIES_LARGE: entries_large_q = val;
      hpt_pkg::CFG_TABLES:        tables_q = val[1:0];
      hpt_pkg::CFG_PROBE_LIMIT:   probe_limit_q = val;
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_va();
    logic [47:0] v;
    int k;
    v = 48'({$urandom, $urandom});
    if (recent_va.size() != 0 && $urandom_range(0, 2) != 0) begin
      v = recent_va[$urandom_range(0, recent_va.size() - 1)];
      k = $urandom_range(0, 47);
      if ($urandom_range(0, 1) != 0) v[k] = ~v[k];
    end else begin
      v = v >> $urandom_range(0, 40);
      recent_va = {recent_va, v};
      if (recent_va.size() > 40) void'(recent_va.pop_front());
    end
    return v;
  endfunction

  task automatic queue_cmd(logic [1:0] c, logic [47:0] va, logic [39:0] p, logic sel);
    cmd_beat_t b;
    b.cmd = c;
    b.vaddr = va;
    b.new_ppn = p;
    b.table_sel = sel;
    pending_cmds = {pending_cmds, b};
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      queue_cmd(r < 9 ? hpt_pkg::CMD_LOOKUP : r < 14 ? hpt_pkg::CMD_INSERT :
                r < 19 ? hpt_pkg::CMD_DELETE : CMD_RESERVED,
                rand_va(), 40'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    shift_small_q = 12; shift_large_q = 21;
    entries_small_q = 1024; entries_large_q = 1024;
    tables_q = 2; probe_limit_q = 1024;
    for (int i = 0; i < 2 * DEPTH; i++) begin
      tag_used[i] = 1'b0;
      blk_valid[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fault fill, hit, insert both tables, delete, unknown, extremes
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'h0000_0000_1000, 40'hAB_CDEF_0123, 1'b0);
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'h0000_0000_1000, 40'h0, 1'b0);
    queue_cmd(hpt_pkg::CMD_INSERT, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0);
    queue_cmd(hpt_pkg::CMD_INSERT, 48'h0000_0000_1000, 40'h12_3456_789A, 1'b0);
    queue_cmd(hpt_pkg::CMD_DELETE, 48'h0000_0000_1000, 40'h0, 1'b0);
    queue_cmd(hpt_pkg::CMD_DELETE, 48'h0000_0000_1000, 40'h0, 1'b0);
    queue_cmd(CMD_RESERVED, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'h0, 40'h0, 1'b0);
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'h0000_0040_0000, 40'h1, 1'b0);
    queue_cmd(hpt_pkg::CMD_INSERT, 48'h0, 40'h5, 1'b1);
    queue_cmd(hpt_pkg::CMD_LOOKUP, 48'h0, 40'h6, 1'b0);
    drain_all();

    // tiny tables to hit probe limit and table full
    cfg_write(hpt_pkg::CFG_ENTRIES_SMALL, 11'd2);
    cfg_write(hpt_pkg::CFG_ENTRIES_LARGE, 11'd1);
    cfg_write(hpt_pkg::CFG_PROBE_LIMIT, 11'd1);
    cfg_write(hpt_pkg::CFG_TABLES, 11'd1);
    cfg_write(hpt_pkg::CFG_SHIFT_SMALL, 11'd39);
    cfg_write(hpt_pkg::CFG_SHIFT_LARGE, 11'd0);
    for (int i = 0; i < 8; i++)
      queue_cmd(i % 3 == 2 ? hpt_pkg::CMD_DELETE :
                i % 3 == 1 ? hpt_pkg::CMD_INSERT : hpt_pkg::CMD_LOOKUP,
                48'(i) << 41, 40'(i + 100), i[0]);
    // long receiver stall while the sender keeps going
    hold_start = 1'b1;
    random_phase(60);
    drain_all();

    cfg_write(hpt_pkg::CFG_ENTRIES_SMALL, 11'd0);
    cfg_write(hpt_pkg::CFG_ENTRIES_LARGE, 11'h7FF);
    cfg_write(hpt_pkg::CFG_PROBE_LIMIT, 11'h7FF);
    cfg_write(hpt_pkg::CFG_TABLES, 11'd3);
    cfg_write(hpt_pkg::CFG_SHIFT_SMALL, 11'd63);
    cfg_write(hpt_pkg::CFG_SHIFT_LARGE, 11'd12);
    random_phase(200);
    drain_all();

    cfg_write(hpt_pkg::CFG_ENTRIES_SMALL, 11'd7);
    cfg_write(hpt_pkg::CFG_ENTRIES_LARGE, 11'd13);
    cfg_write(hpt_pkg::CFG_PROBE_LIMIT, 11'd5);
    cfg_write(hpt_pkg::CFG_TABLES, 11'd0);
    cfg_write(hpt_pkg::CFG_SHIFT_SMALL, 11'd12);
    cfg_write(hpt_pkg::CFG_SHIFT_LARGE, 11'd21);
    random_phase(300);
    drain_all();

    cfg_write(hpt_pkg::CFG_ENTRIES_SMALL, 11'd1024);
    cfg_write(hpt_pkg::CFG_ENTRIES_LARGE, 11'd1024);
    cfg_write(hpt_pkg::CFG_PROBE_LIMIT, 11'd1024);
    cfg_write(hpt_pkg::CFG_TABLES, 11'd2);
    random_phase(500);
    drain_all();

    cfg_write(hpt_pkg::CFG_ENTRIES_SMALL, 11'd31);
    cfg_write(hpt_pkg::CFG_PROBE_LIMIT, 11'd40);
    idle_free = 1'b1;
    random_phase(320);
    drain_all();

    $display("%0d command beats accepted, %0d results checked", accepted, checked);
    $display("%0d hits, %0d fault fills, %0d table full answers", hits, faults, fulls);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
